// ===== rtl/ist_pkg.sv =====
// Shared types, constants and codes of the identifier-to-slot hash table.
package ist_pkg;

	localparam int SLOT_COUNT_DEF   = 64;
	localparam int BUCKET_COUNT_DEF = 128;
	localparam int KEY_W            = 32;
	localparam int FUNC_W           = 2;
	localparam int STATUS_W         = 3;
	localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOOKUP  = 2'd0,
		FUNC_CREATE  = 2'd1,
		FUNC_RELEASE = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND      = 3'd0,
		ST_CREATED    = 3'd1,
		ST_NOT_FOUND  = 3'd2,
		ST_FULL       = 3'd3,
		ST_RELEASED   = 3'd4,
		ST_NOT_ACTIVE = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_HASH_WAIT,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_WALK_RD,
		S_WALK_CHK,
		S_POP_RD,
		S_POP_WR,
		S_REL_RD,
		S_REL_CHK,
		S_LIST_RD,
		S_LIST_WR,
		S_DONE
	} state_t;

	// what the current probe is looking for
	typedef enum logic [1:0] {
		M_FIND,
		M_ERASE,
		M_REINS
	} mode_t;

	// bucket write sources
	typedef enum logic [2:0] {
		BW_SWEEP,
		BW_CLR_PROBE,
		BW_CLR_WALK,
		BW_FILL_REINS,
		BW_FILL_NEW
	} bkt_wsel_t;

	typedef struct packed {
		logic      accept;
		logic      hash_start;
		logic      probe_init;
		logic      probe_adv;
		logic      walk_init;
		logic      walk_adv;
		logic      load_walk;
		logic      load_owner;
		logic      bkt_rd_walk;
		logic      bkt_we;
		bkt_wsel_t bkt_wsel;
		logic      pop_commit;
		logic      list_rd;
		logic      list_wr;
		logic      set_res;
		status_t   res_code;
		logic      out_load;
		logic      clr_step;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              hash_done;
		logic              bkt_valid;
		logic              bkt_match;
		logic              probe_last;
		logic              walk_last;
		logic              pool_full;
		logic              sidx_bad;
		logic              out_free;
		logic              clr_last;
	} sts_t;

endpackage

// ===== rtl/ist_if.sv =====
// Request and result channel interfaces of the identifier-to-slot hash table.
interface ist_req_if #(
	parameter int SLOT_W = 6
);
	logic                       valid;
	logic                       ready;
	logic [ist_pkg::FUNC_W-1:0] func;
	logic [ist_pkg::KEY_W-1:0]  key_id;
	logic [SLOT_W-1:0]          slot_index;

	modport source (output valid, output func, output key_id, output slot_index, input ready);
	modport sink   (input valid, input func, input key_id, input slot_index, output ready);
endinterface

interface ist_rsp_if #(
	parameter int SLOT_W = 6,
	parameter int LIVE_W = 7
);
	logic                         valid;
	logic                         ready;
	logic [ist_pkg::STATUS_W-1:0] status;
	logic [SLOT_W-1:0]            slot_out;
	logic [LIVE_W-1:0]            live_count;

	modport source (output valid, output status, output slot_out, output live_count, input ready);
	modport sink   (input valid, input status, input slot_out, input live_count, output ready);
endinterface

// ===== rtl/id_slot_hash_table.sv =====
// Top level of the identifier-to-slot hash table with free-slot stack and live list.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------
//  req     | in  | valid / ready | func, key_id, slot_index
//  rsp     | out | valid / ready | status, slot_out, live_count
//
// Sequence: every request runs alone through the sequencer. The hash is a
//   registered multiply, then for a power-of-two bucket count the low product
//   bits are taken, otherwise a digit-serial reduction, 4 bits a cycle over
//   the 64-bit product. Each bucket probe is a registered memory read, then a
//   compare, so a lookup runs the hash and its probes from acceptance until
//   its result is posted. A create adds a read and a write for the stack pop;
//   a release adds a read and a check of the slot, a hash and probe for the
//   owner key, then per following cluster entry a read, a rehash and a reprobe,
//   then a read of the empty bucket that ends the cluster and list upkeep.
// Reset: a clearing pass over all buckets and slots wipes the
//   bucket valid flags and slot live flags; req.ready stays low meanwhile.
// Stalls: the result sits in an output register; a held rsp only delays the
//   next request once its own result is ready to be posted.
module id_slot_hash_table #(
	parameter int SLOT_COUNT   = ist_pkg::SLOT_COUNT_DEF,
	parameter int BUCKET_COUNT = ist_pkg::BUCKET_COUNT_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ist_req_if.sink   req,
	ist_rsp_if.source rsp
);
	ist_pkg::cmd_t   cmd;
	ist_pkg::sts_t   sts;
	ist_pkg::state_t state;

	// sequencer
	ist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_func  (req.func),
		.sts      (sts),
		.in_ready (req.ready),
		.cmd      (cmd),
		.state    (state)
	);

	// tables, counters and output register
	ist_dp #(
		.SLOT_COUNT   (SLOT_COUNT),
		.BUCKET_COUNT (BUCKET_COUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_func    (req.func),
		.in_key     (req.key_id),
		.in_sidx    (req.slot_index),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_status (rsp.status),
		.out_slot   (rsp.slot_out),
		.out_live   (rsp.live_count)
	);

	// no request is taken during the clearing pass
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state == ist_pkg::S_CLEAR) |-> !req.ready)
		else $error("request taken during clearing pass");

	// a result is never posted over one still waiting
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten");

	// the hash unit only finishes while the sequencer waits for it
	a_hash_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.hash_done |-> (state == ist_pkg::S_HASH_WAIT))
		else $error("hash result outside wait state");

	// live count never exceeds the pool
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.live_count <= SLOT_COUNT))
		else $error("live count beyond pool size");
endmodule

// ===== rtl/ist_hash.sv =====
// Multiplicative hash: registered product, low bits or digit-serial reduction.
module ist_hash #(
	parameter int BUCKET_COUNT = ist_pkg::BUCKET_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [ist_pkg::KEY_W-1:0]       key,
	output logic                            done,
	output logic [$clog2(BUCKET_COUNT)-1:0] hash
);
	localparam int BW    = $clog2(BUCKET_COUNT);
	localparam bit POW2  = ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0);
	localparam int PW    = 2 * ist_pkg::KEY_W;
	localparam int DIG   = 4;
	localparam int STEPS = PW / DIG;
	localparam int NW    = $clog2(STEPS);

	logic [PW-1:0] sh_q;
	logic [BW-1:0] rem_q;
	logic [BW-1:0] rem_d;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [PW-1:0] prod;

	assign prod = PW'(key) * PW'(ist_pkg::HASH_MULT);

	// remainder update, most significant bit first
	always_comb begin
		logic [BW:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < DIG; i++) begin
			r = {r[BW-1:0], sh_q[PW-1-i]};
			if (r >= (BW+1)'(BUCKET_COUNT)) r = r - (BW+1)'(BUCKET_COUNT);
		end
		rem_d = r[BW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (POW2 || cnt_q == NW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= prod;
			rem_q <= '0;
		end else if (busy_q) begin
			if (POW2) begin
				rem_q <= sh_q[BW-1:0];
			end else begin
				rem_q <= rem_d;
				sh_q  <= sh_q << DIG;
			end
		end
	end

	assign done = done_q;
	assign hash = rem_q;
endmodule

// ===== rtl/ist_ctrl.sv =====
// Sequencer of the hash table: probe, cluster repair, pop/push and list upkeep.
module ist_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [ist_pkg::FUNC_W-1:0] in_func,
	input  ist_pkg::sts_t              sts,
	output logic                       in_ready,
	output ist_pkg::cmd_t              cmd,
	output ist_pkg::state_t            state
);
	ist_pkg::state_t state_q, state_d;
	ist_pkg::mode_t  mode_q, mode_d;
	logic hit, empty, last;

	assign hit   = sts.bkt_valid && sts.bkt_match;
	assign empty = !sts.bkt_valid;
	assign last  = sts.probe_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ist_pkg::S_CLEAR;
			mode_q  <= ist_pkg::M_FIND;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		case (state_q)
			ist_pkg::S_CLEAR: begin
				if (sts.clr_last) state_d = ist_pkg::S_IDLE;
			end
			ist_pkg::S_IDLE: begin
				if (in_valid) begin
					if (in_func == ist_pkg::FUNC_LOOKUP || in_func == ist_pkg::FUNC_CREATE) begin
						state_d = ist_pkg::S_HASH;
						mode_d  = ist_pkg::M_FIND;
					end else if (in_func == ist_pkg::FUNC_RELEASE) begin
						state_d = ist_pkg::S_REL_RD;
					end else begin
						state_d = ist_pkg::S_DONE;
					end
				end
			end
			ist_pkg::S_HASH:      state_d = ist_pkg::S_HASH_WAIT;
			ist_pkg::S_HASH_WAIT: begin
				if (sts.hash_done) state_d = ist_pkg::S_PROBE_RD;
			end
			ist_pkg::S_PROBE_RD:  state_d = ist_pkg::S_PROBE_CHK;
			ist_pkg::S_PROBE_CHK: begin
				case (mode_q)
					ist_pkg::M_FIND: begin
						if (hit) state_d = ist_pkg::S_DONE;
						else if (empty || last)
							state_d = (sts.func == ist_pkg::FUNC_CREATE && !sts.pool_full && empty)
								? ist_pkg::S_POP_RD : ist_pkg::S_DONE;
						else state_d = ist_pkg::S_PROBE_RD;
					end
					ist_pkg::M_ERASE: begin
						if (hit) state_d = ist_pkg::S_WALK_RD;
						else if (empty || last) state_d = ist_pkg::S_LIST_RD;
						else state_d = ist_pkg::S_PROBE_RD;
					end
					ist_pkg::M_REINS: begin
						if (empty || hit || last)
							state_d = sts.walk_last ? ist_pkg::S_LIST_RD : ist_pkg::S_WALK_RD;
						else state_d = ist_pkg::S_PROBE_RD;
					end
					default: state_d = ist_pkg::S_DONE;
				endcase
			end
			ist_pkg::S_WALK_RD:  state_d = ist_pkg::S_WALK_CHK;
			ist_pkg::S_WALK_CHK: begin
				if (sts.bkt_valid) begin
					state_d = ist_pkg::S_HASH;
					mode_d  = ist_pkg::M_REINS;
				end else begin
					state_d = ist_pkg::S_LIST_RD;
				end
			end
			ist_pkg::S_POP_RD:  state_d = ist_pkg::S_POP_WR;
			ist_pkg::S_POP_WR:  state_d = ist_pkg::S_DONE;
			ist_pkg::S_REL_RD:  state_d = ist_pkg::S_REL_CHK;
			ist_pkg::S_REL_CHK: begin
				if (sts.sidx_bad) begin
					state_d = ist_pkg::S_DONE;
				end else begin
					state_d = ist_pkg::S_HASH;
					mode_d  = ist_pkg::M_ERASE;
				end
			end
			ist_pkg::S_LIST_RD: state_d = ist_pkg::S_LIST_WR;
			ist_pkg::S_LIST_WR: state_d = ist_pkg::S_DONE;
			ist_pkg::S_DONE: begin
				if (sts.out_free) state_d = ist_pkg::S_IDLE;
			end
			default: state_d = ist_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.bkt_wsel = ist_pkg::BW_SWEEP;
		cmd.res_code = ist_pkg::ST_NOT_FOUND;
		in_ready     = 1'b0;
		case (state_q)
			ist_pkg::S_CLEAR: begin
				cmd.clr_step = 1'b1;
				cmd.bkt_we   = 1'b1;
				cmd.bkt_wsel = ist_pkg::BW_SWEEP;
			end
			ist_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					// unused code answers not found at once
					if (in_func != ist_pkg::FUNC_LOOKUP && in_func != ist_pkg::FUNC_CREATE &&
					    in_func != ist_pkg::FUNC_RELEASE) begin
						cmd.set_res  = 1'b1;
						cmd.res_code = ist_pkg::ST_NOT_FOUND;
					end
				end
			end
			ist_pkg::S_HASH: cmd.hash_start = 1'b1;
			ist_pkg::S_HASH_WAIT: begin
				if (sts.hash_done) cmd.probe_init = 1'b1;
			end
			ist_pkg::S_PROBE_CHK: begin
				case (mode_q)
					ist_pkg::M_FIND: begin
						if (hit) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = ist_pkg::ST_FOUND;
						end else if (empty || last) begin
							if (sts.func != ist_pkg::FUNC_CREATE) begin
								cmd.set_res  = 1'b1;
								cmd.res_code = ist_pkg::ST_NOT_FOUND;
							end else if (sts.pool_full || !empty) begin
								cmd.set_res  = 1'b1;
								cmd.res_code = ist_pkg::ST_FULL;
							end
						end else begin
							cmd.probe_adv = 1'b1;
						end
					end
					ist_pkg::M_ERASE: begin
						if (hit) begin
							cmd.bkt_we    = 1'b1;
							cmd.bkt_wsel  = ist_pkg::BW_CLR_PROBE;
							cmd.walk_init = 1'b1;
						end else if (!(empty || last)) begin
							cmd.probe_adv = 1'b1;
						end
					end
					ist_pkg::M_REINS: begin
						if (empty || hit) begin
							cmd.bkt_we   = 1'b1;
							cmd.bkt_wsel = ist_pkg::BW_FILL_REINS;
						end
						if (empty || hit || last) cmd.walk_adv = !sts.walk_last;
						else cmd.probe_adv = 1'b1;
					end
					default: begin
						cmd.set_res  = 1'b1;
						cmd.res_code = ist_pkg::ST_NOT_FOUND;
					end
				endcase
			end
			ist_pkg::S_WALK_RD: cmd.bkt_rd_walk = 1'b1;
			ist_pkg::S_WALK_CHK: begin
				if (sts.bkt_valid) begin
					cmd.bkt_we    = 1'b1;
					cmd.bkt_wsel  = ist_pkg::BW_CLR_WALK;
					cmd.load_walk = 1'b1;
				end
			end
			ist_pkg::S_POP_WR: begin
				cmd.pop_commit = 1'b1;
				cmd.bkt_we     = 1'b1;
				cmd.bkt_wsel   = ist_pkg::BW_FILL_NEW;
				cmd.set_res    = 1'b1;
				cmd.res_code   = ist_pkg::ST_CREATED;
			end
			ist_pkg::S_REL_CHK: begin
				if (sts.sidx_bad) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ist_pkg::ST_NOT_ACTIVE;
				end else begin
					cmd.load_owner = 1'b1;
				end
			end
			ist_pkg::S_LIST_RD: cmd.list_rd = 1'b1;
			ist_pkg::S_LIST_WR: begin
				cmd.list_wr  = 1'b1;
				cmd.set_res  = 1'b1;
				cmd.res_code = ist_pkg::ST_RELEASED;
			end
			ist_pkg::S_DONE: begin
				if (sts.out_free) cmd.out_load = 1'b1;
			end
			default: ;
		endcase
	end

	assign state = state_q;
endmodule

// ===== rtl/ist_dp.sv =====
// Datapath: bucket table, slot owners, free stack, live list and result register.
module ist_dp #(
	parameter int SLOT_COUNT   = ist_pkg::SLOT_COUNT_DEF,
	parameter int BUCKET_COUNT = ist_pkg::BUCKET_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ist_pkg::cmd_t                   cmd,
	output ist_pkg::sts_t                   sts,
	input  logic [ist_pkg::FUNC_W-1:0]      in_func,
	input  logic [ist_pkg::KEY_W-1:0]       in_key,
	input  logic [$clog2(SLOT_COUNT)-1:0]   in_sidx,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [ist_pkg::STATUS_W-1:0]    out_status,
	output logic [$clog2(SLOT_COUNT)-1:0]   out_slot,
	output logic [$clog2(SLOT_COUNT+1)-1:0] out_live
);
	localparam int KW    = ist_pkg::KEY_W;
	localparam int SW    = $clog2(SLOT_COUNT);
	localparam int LW    = $clog2(SLOT_COUNT + 1);
	localparam int BW    = $clog2(BUCKET_COUNT);
	localparam int CMAX  = (BUCKET_COUNT > SLOT_COUNT) ? BUCKET_COUNT : SLOT_COUNT;
	localparam int CW    = $clog2(CMAX);
	localparam int BWORD = 1 + KW + SW;
	localparam int OWORD = 1 + KW;

	function automatic logic [BW-1:0] nxt(input logic [BW-1:0] b);
		return (b == BW'(BUCKET_COUNT - 1)) ? '0 : b + 1'b1;
	endfunction

	// memories
	logic [BWORD-1:0] bkt_mem   [BUCKET_COUNT];
	logic [OWORD-1:0] slot_mem  [SLOT_COUNT];
	logic [SW-1:0]    lpos_mem  [SLOT_COUNT];
	logic [SW-1:0]    llist_mem [SLOT_COUNT];
	logic [SW-1:0]    stk_mem   [SLOT_COUNT];

	logic [BWORD-1:0] bkt_rd_q;
	logic [OWORD-1:0] slot_rd_q;
	logic [SW-1:0]    lpos_rd_q;
	logic [SW-1:0]    llist_rd_q;
	logic [SW-1:0]    stk_rd_q;

	// operation registers
	logic [ist_pkg::FUNC_W-1:0] func_q;
	logic [KW-1:0]              key_q;
	logic [SW-1:0]              sidx_q;
	logic [KW-1:0]              pkey_q;
	logic [SW-1:0]              rs_q;
	logic [SW-1:0]              pos_q;
	logic [BW-1:0]              probe_q;
	logic [BW-1:0]              n_q;
	logic [BW-1:0]              walk_q;
	logic [BW-1:0]              k_q;
	ist_pkg::status_t           res_status_q;
	logic [SW-1:0]              res_slot_q;

	// control registers
	logic [LW-1:0] live_total_q;
	logic [LW-1:0] min_q;          // lowest stack depth ever reached
	logic [CW-1:0] clr_q;
	logic          out_valid_q;
	ist_pkg::status_t out_status_q;
	logic [SW-1:0] out_slot_q;
	logic [LW-1:0] out_live_q;

	logic          hash_done;
	logic [BW-1:0] hash;

	ist_hash #(.BUCKET_COUNT(BUCKET_COUNT)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.hash_start),
		.key    (pkey_q),
		.done   (hash_done),
		.hash   (hash)
	);

	logic          bkt_v;
	logic [KW-1:0] bkt_k;
	logic [SW-1:0] bkt_s;
	logic          slot_live;
	logic [KW-1:0] slot_key;
	logic [LW-1:0] last_w;
	logic [LW-1:0] push_idx;
	logic [LW-1:0] pop_idx;
	logic [SW-1:0] pop_s;
	logic          move;
	logic          clr_in_b;
	logic          clr_in_s;
	logic [SW-1:0] res_slot_d;

	assign bkt_v     = bkt_rd_q[BWORD-1];
	assign bkt_k     = bkt_rd_q[SW +: KW];
	assign bkt_s     = bkt_rd_q[SW-1:0];
	assign slot_live = slot_rd_q[OWORD-1];
	assign slot_key  = slot_rd_q[KW-1:0];
	assign last_w    = live_total_q - 1'b1;
	assign push_idx  = LW'(SLOT_COUNT) - live_total_q;
	assign pop_idx   = push_idx - 1'b1;
	// stack entries below the lowest depth ever reached were never written; their initial value is computed instead
	assign pop_s     = (pop_idx < min_q) ? (SW'(SLOT_COUNT - 1) - pop_idx[SW-1:0]) : stk_rd_q;
	assign move      = LW'(pos_q) < last_w;
	assign clr_in_b  = {1'b0, clr_q} < (CW+1)'(BUCKET_COUNT);
	assign clr_in_s  = {1'b0, clr_q} < (CW+1)'(SLOT_COUNT);

	// bucket memory
	logic             bkt_we;
	logic [BW-1:0]    bkt_wa;
	logic [BWORD-1:0] bkt_wd;
	logic [BW-1:0]    bkt_ra;

	always_comb begin
		bkt_we = cmd.bkt_we;
		bkt_wa = probe_q;
		bkt_wd = '0;
		case (cmd.bkt_wsel)
			ist_pkg::BW_SWEEP: begin
				bkt_we = cmd.bkt_we && clr_in_b;
				bkt_wa = clr_q[BW-1:0];
			end
			ist_pkg::BW_CLR_PROBE:  bkt_wa = probe_q;
			ist_pkg::BW_CLR_WALK:   bkt_wa = walk_q;
			ist_pkg::BW_FILL_REINS: bkt_wd = {1'b1, pkey_q, rs_q};
			ist_pkg::BW_FILL_NEW:   bkt_wd = {1'b1, key_q, pop_s};
			default:                bkt_we = 1'b0;
		endcase
	end

	assign bkt_ra = cmd.bkt_rd_walk ? walk_q : probe_q;

	always_ff @(posedge clk) begin
		if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
		bkt_rd_q <= bkt_mem[bkt_ra];
	end

	// slot owner memory
	logic             slot_we;
	logic [SW-1:0]    slot_wa;
	logic [OWORD-1:0] slot_wd;

	always_comb begin
		slot_we = 1'b0;
		slot_wa = sidx_q;
		slot_wd = '0;
		if (cmd.clr_step) begin
			slot_we = clr_in_s;
			slot_wa = clr_q[SW-1:0];
		end else if (cmd.pop_commit) begin
			slot_we = 1'b1;
			slot_wa = pop_s;
			slot_wd = {1'b1, key_q};
		end else if (cmd.list_rd) begin
			slot_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		slot_rd_q <= slot_mem[sidx_q];
	end

	// live list and positions, swap-remove on release
	always_ff @(posedge clk) begin
		if (cmd.pop_commit) begin
			lpos_mem[pop_s]                  <= live_total_q[SW-1:0];
			llist_mem[live_total_q[SW-1:0]]  <= pop_s;
		end else if (cmd.list_wr && move) begin
			lpos_mem[llist_rd_q] <= pos_q;
			llist_mem[pos_q]     <= llist_rd_q;
		end
		lpos_rd_q  <= lpos_mem[sidx_q];
		llist_rd_q <= llist_mem[last_w[SW-1:0]];
	end

	// free stack
	always_ff @(posedge clk) begin
		if (cmd.list_rd) stk_mem[push_idx[SW-1:0]] <= sidx_q;
		stk_rd_q <= stk_mem[pop_idx[SW-1:0]];
	end

	always_comb begin
		case (cmd.res_code)
			ist_pkg::ST_FOUND:    res_slot_d = bkt_s;
			ist_pkg::ST_CREATED:  res_slot_d = pop_s;
			ist_pkg::ST_RELEASED: res_slot_d = sidx_q;
			default:              res_slot_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= in_func;
			key_q  <= in_key;
			sidx_q <= in_sidx;
			pkey_q <= in_key;
		end
		if (cmd.load_walk) begin
			pkey_q <= bkt_k;
			rs_q   <= bkt_s;
		end
		if (cmd.load_owner) begin
			pkey_q <= slot_key;
			pos_q  <= lpos_rd_q;
		end
		if (cmd.probe_init) begin
			probe_q <= hash;
			n_q     <= '0;
		end else if (cmd.probe_adv) begin
			probe_q <= nxt(probe_q);
			n_q     <= n_q + 1'b1;
		end
		if (cmd.walk_init) begin
			walk_q <= nxt(probe_q);
			k_q    <= '0;
		end else if (cmd.walk_adv) begin
			walk_q <= nxt(walk_q);
			k_q    <= k_q + 1'b1;
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			res_slot_q   <= res_slot_d;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_live_q   <= live_total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_total_q <= '0;
			min_q        <= LW'(SLOT_COUNT);
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.pop_commit) begin
				live_total_q <= live_total_q + 1'b1;
				if (pop_idx < min_q) min_q <= pop_idx;
			end else if (cmd.list_wr) begin
				live_total_q <= last_w;
			end
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts            = '0;
		sts.func       = func_q;
		sts.hash_done  = hash_done;
		sts.bkt_valid  = bkt_v;
		sts.bkt_match  = (bkt_k == pkey_q);
		sts.probe_last = (n_q == BW'(BUCKET_COUNT - 1));
		sts.walk_last  = (k_q == BW'(BUCKET_COUNT - 1));
		sts.pool_full  = (live_total_q >= LW'(SLOT_COUNT));
		sts.sidx_bad   = ({1'b0, sidx_q} >= (SW+1)'(SLOT_COUNT)) || !slot_live ||
		                 (live_total_q == '0);
		sts.out_free   = !out_valid_q || out_ready;
		sts.clr_last   = (clr_q == CW'(CMAX - 1));
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot   = out_slot_q;
	assign out_live   = out_live_q;
endmodule

// ===== dv/tb_id_slot_hash_table.sv =====
// Testbench for the identifier-to-slot hash table: random and directed requests.
module tb_id_slot_hash_table;

	localparam int NSLOT   = 64;
	localparam int NBUCKET = 128;
	localparam int WATCHDOG_LIMIT = 50000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] key_id;
		logic [5:0]  slot_index;
	} req_item_t;

	typedef struct packed {
		ist_pkg::status_t status;
		logic [5:0]       slot_out;
		logic [6:0]       live_count;
	} rsp_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ist_req_if #(.SLOT_W(6)) req ();
	ist_rsp_if #(.SLOT_W(6), .LIVE_W(7)) rsp ();

	id_slot_hash_table #(.SLOT_COUNT(NSLOT), .BUCKET_COUNT(NBUCKET)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always #4 clk = ~clk;

	// Shadow copy of the table, pool and live list
	logic        mdl_bvalid [NBUCKET];
	logic [31:0] mdl_bkey   [NBUCKET];
	logic [5:0]  mdl_bslot  [NBUCKET];
	logic [31:0] mdl_owner  [NSLOT];
	logic        mdl_live   [NSLOT];
	logic [5:0]  mdl_stack  [NSLOT];
	int          mdl_depth;
	logic [5:0]  mdl_list   [NSLOT];
	int          mdl_pos    [NSLOT];
	int          mdl_total;

	req_item_t pending_reqs[$];
	rsp_item_t expected_rsps[$];
	int  n_fail = 0;
	int  idle_cycles = 0;
	bit  hold_sender = 1'b0;
	int  send_gap = 0;
	int  recv_gap = 0;
	logic [31:0] recent_keys[$];

	function automatic int home_bucket(logic [31:0] key);
		logic [63:0] prod;
		prod = 64'(key) * 64'd2654435761;
		return int'(prod % NBUCKET);
	endfunction

	function automatic bit table_find(logic [31:0] key, output logic [5:0] slot);
		int b;
		b = home_bucket(key);
		slot = '0;
		for (int n = 0; n < NBUCKET; n++) begin
			if (!mdl_bvalid[b])
				return 1'b0;
			if (mdl_bkey[b] == key) begin
				slot = mdl_bslot[b];
				return 1'b1;
			end
			b = (b + 1) % NBUCKET;
		end
		return 1'b0;
	endfunction

	function automatic bit table_put(logic [31:0] key, logic [5:0] slot);
		int b;
		b = home_bucket(key);
		for (int n = 0; n < NBUCKET; n++) begin
			if (!mdl_bvalid[b] || mdl_bkey[b] == key) begin
				mdl_bvalid[b] = 1'b1;
				mdl_bkey[b]   = key;
				mdl_bslot[b]  = slot;
				return 1'b1;
			end
			b = (b + 1) % NBUCKET;
		end
		return 1'b0;
	endfunction

	// Clear the key's bucket, then pull out and reinsert the rest of its cluster
	function automatic void table_remove(logic [31:0] key);
		int b;
		logic [31:0] rk;
		logic [5:0] rs;
		b = home_bucket(key);
		for (int n = 0; n < NBUCKET; n++) begin
			if (!mdl_bvalid[b])
				return;
			if (mdl_bkey[b] == key) begin
				mdl_bvalid[b] = 1'b0;
				mdl_bkey[b] = '0;
				mdl_bslot[b] = '0;
				b = (b + 1) % NBUCKET;
				for (int k = 0; k < NBUCKET && mdl_bvalid[b]; k++) begin
					rk = mdl_bkey[b];
					rs = mdl_bslot[b];
					mdl_bvalid[b] = 1'b0;
					mdl_bkey[b] = '0;
					mdl_bslot[b] = '0;
					void'(table_put(rk, rs));
					b = (b + 1) % NBUCKET;
				end
				return;
			end
			b = (b + 1) % NBUCKET;
		end
	endfunction

	function automatic bit find_live(logic [31:0] key, output logic [5:0] slot);
		logic [5:0] s;
		slot = '0;
		if (!table_find(key, s))
			return 1'b0;
		if (!mdl_live[s] || mdl_owner[s] != key)
			return 1'b0;
		slot = s;
		return 1'b1;
	endfunction

	function automatic void table_reset();
		for (int i = 0; i < NBUCKET; i++) begin
			mdl_bvalid[i] = 1'b0;
			mdl_bkey[i] = '0;
			mdl_bslot[i] = '0;
		end
		for (int i = 0; i < NSLOT; i++) begin
			mdl_owner[i] = '0;
			mdl_live[i] = 1'b0;
			mdl_stack[i] = 6'(NSLOT - 1 - i);
			mdl_list[i] = '0;
			mdl_pos[i] = 0;
		end
		mdl_depth = NSLOT;
		mdl_total = 0;
	endfunction

	function automatic rsp_item_t apply_request(req_item_t r);
		rsp_item_t o;
		logic [5:0] s;
		int p, last;
		o.status = ist_pkg::ST_NOT_FOUND;
		o.slot_out = '0;
		case (r.func)
			ist_pkg::FUNC_LOOKUP: begin
				if (find_live(r.key_id, s)) begin
					o.status = ist_pkg::ST_FOUND;
					o.slot_out = s;
				end
			end
			ist_pkg::FUNC_CREATE: begin
				if (find_live(r.key_id, s)) begin
					o.status = ist_pkg::ST_FOUND;
					o.slot_out = s;
				end else if (mdl_depth == 0 || mdl_total >= NSLOT) begin
					o.status = ist_pkg::ST_FULL;
				end else begin
					mdl_depth--;
					s = mdl_stack[mdl_depth];
					if (!table_put(r.key_id, s)) begin
						mdl_depth++;
						o.status = ist_pkg::ST_FULL;
					end else begin
						mdl_owner[s] = r.key_id;
						mdl_live[s] = 1'b1;
						mdl_pos[s] = mdl_total;
						mdl_list[mdl_total] = s;
						mdl_total++;
						o.status = ist_pkg::ST_CREATED;
						o.slot_out = s;
					end
				end
			end
			ist_pkg::FUNC_RELEASE: begin
				if (!mdl_live[r.slot_index] || mdl_total == 0) begin
					o.status = ist_pkg::ST_NOT_ACTIVE;
				end else begin
					p = mdl_pos[r.slot_index];
					last = mdl_total - 1;
					table_remove(mdl_owner[r.slot_index]);
					mdl_live[r.slot_index] = 1'b0;
					if (p < last) begin
						mdl_list[p] = mdl_list[last];
						mdl_pos[mdl_list[last]] = p;
					end
					mdl_total = last;
					if (mdl_depth < NSLOT) begin
						mdl_stack[mdl_depth] = r.slot_index;
						mdl_depth++;
					end
					o.status = ist_pkg::ST_RELEASED;
					o.slot_out = r.slot_index;
				end
			end
			default: ;
		endcase
		o.live_count = 7'(mdl_total);
		return o;
	endfunction

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			return 0;
		if (sel < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_key();
		// Reuse known keys often so that lookups and creates hit existing entries
		if (recent_keys.size() > 0 && $urandom_range(0, 2) != 0)
			return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
		return $urandom();
	endfunction

	task automatic queue_request(logic [1:0] f, logic [31:0] k, logic [5:0] s);
		req_item_t r;
		r.func = f;
		r.key_id = k;
		r.slot_index = s;
		pending_reqs.push_back(r);
		if (f == ist_pkg::FUNC_CREATE && recent_keys.size() < 200)
			recent_keys.push_back(k);
	endtask

	// Driver: one request on the bus at a time, random gaps between them.
	// valid stays high across back-to-back requests, one assignment per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.func <= '0;
			req.key_id <= '0;
			req.slot_index <= '0;
			send_gap <= 0;
		end else begin
			if (req.valid && req.ready) begin
				expected_rsps.push_back(apply_request({req.func, req.key_id,
					req.slot_index}));
			end
			if (!req.valid || req.ready) begin
				if (send_gap > 0) begin
					req.valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_reqs.size() > 0 && !hold_sender) begin
					req.valid <= 1'b1;
					{req.func, req.key_id, req.slot_index} <= pending_reqs.pop_front();
					send_gap <= pick_gap();
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure on rsp, each result checked in order
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result status=%0d slot=%0d live=%0d", $time,
						rsp.status, rsp.slot_out, rsp.live_count);
					n_fail++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.status !== want.status || rsp.slot_out !== want.slot_out ||
						rsp.live_count !== want.live_count) begin
						$display("%0t: mismatch expected status=%0d slot=%0d live=%0d,",
							$time, want.status, want.slot_out, want.live_count,
							" got status=%0d slot=%0d live=%0d",
							rsp.status, rsp.slot_out, rsp.live_count);
						n_fail++;
					end
				end
			end
			if (recv_gap > 0) begin
				rsp.ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				rsp.ready <= 1'b1;
				recv_gap <= pick_gap();
			end
		end
	end

	// Watchdog: counts cycles in which no request or result moves
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int sel;
		table_reset();
		// directed: extremes, every func, each corner
		queue_request(ist_pkg::FUNC_LOOKUP, 32'h0, 6'd0);
		queue_request(ist_pkg::FUNC_RELEASE, 32'h0, 6'd0);          // release of an idle slot
		queue_request(ist_pkg::FUNC_CREATE, 32'h0, 6'd63);
		queue_request(ist_pkg::FUNC_CREATE, 32'hFFFF_FFFF, 6'd0);
		queue_request(ist_pkg::FUNC_CREATE, 32'h0, 6'd0);            // already present
		queue_request(ist_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd63);
		queue_request(FUNC_UNUSED, 32'hFFFF_FFFF, 6'd63);            // unused func code
		// keys with the same home bucket build a cluster: key*odd mod 128
		queue_request(ist_pkg::FUNC_CREATE, 32'd128, 6'd0);
		queue_request(ist_pkg::FUNC_CREATE, 32'd256, 6'd0);
		queue_request(ist_pkg::FUNC_CREATE, 32'd384, 6'd0);
		queue_request(ist_pkg::FUNC_RELEASE, 32'hFFFF_FFFF, 6'd2);   // middle of cluster
		queue_request(ist_pkg::FUNC_LOOKUP, 32'd256, 6'd0);
		queue_request(ist_pkg::FUNC_LOOKUP, 32'd384, 6'd0);
		queue_request(ist_pkg::FUNC_RELEASE, 32'h0, 6'd0);
		queue_request(ist_pkg::FUNC_LOOKUP, 32'h0, 6'd0);
		queue_request(ist_pkg::FUNC_RELEASE, 32'h0, 6'd63);
		// fill the pool to exhaustion, then five more creates
		for (int i = 0; i < 66; i++)
			queue_request(ist_pkg::FUNC_CREATE, 32'h5A00_0000 + i * 7, 6'(i));
		queue_request(ist_pkg::FUNC_LOOKUP, 32'h5A00_0000, 6'd0);
		for (int i = 0; i < 64; i++)
			queue_request(ist_pkg::FUNC_RELEASE, $urandom(), 6'(63 - i));

		#1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// random phase; wait mid-way until all results are back
		for (int i = 0; i < 1300; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40)
				queue_request(ist_pkg::FUNC_CREATE, pick_key(), 6'($urandom()));
			else if (sel < 65)
				queue_request(ist_pkg::FUNC_LOOKUP, pick_key(), 6'($urandom()));
			else if (sel < 95)
				queue_request(ist_pkg::FUNC_RELEASE, $urandom(), 6'($urandom()));
			else
				queue_request(FUNC_UNUSED, $urandom(), 6'($urandom()));
			if (i == 650) begin
				wait (pending_reqs.size() == 0);
				@(posedge clk);
				hold_sender = 1'b1;
				wait (expected_rsps.size() == 0 && !req.valid);
				@(posedge clk);
				hold_sender = 1'b0;
			end
		end

		wait (pending_reqs.size() == 0 && !req.valid);
		wait (expected_rsps.size() == 0);
		repeat (400) @(posedge clk);
		if (n_fail == 0 && expected_rsps.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
